// ===== hw/rtl/utf8t_pkg.sv =====
// Shared types, constants and lookup functions for the UTF-8 to UTF-16/32 transcoder.
// No dependencies; used by the decoder, the result queue and the top level.
package utf8t_pkg;

    localparam int unsigned OUT_DEPTH = 4;

    localparam logic [31:0] TILDE_UNIT  = 32'h0000_007E;
    localparam logic [31:0] BMP_MAX     = 32'h0000_FFFF;
    localparam logic [31:0] UNI_MAX     = 32'h0010_FFFF;
    localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;
    localparam logic [31:0] SURR_HIGH   = 32'h0000_D800;
    localparam logic [31:0] SURR_LOW    = 32'h0000_DC00;

    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    typedef struct packed {
        logic [31:0] unit;
        logic        last;
        logic        done;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_out_t;

    // Number of trailing bytes announced by a lead byte.
    function automatic logic [2:0] trail_count(input logic [7:0] b);
        logic [2:0] t;
        if (b < 8'hC0)      t = 3'd0;
        else if (b < 8'hE0) t = 3'd1;
        else if (b < 8'hF0) t = 3'd2;
        else if (b < 8'hF8) t = 3'd3;
        else if (b < 8'hFC) t = 3'd4;
        else                t = 3'd5;
        return t;
    endfunction

    // Residue left by the marker bits of a sequence with the given trail count.
    function automatic logic [31:0] residue(input logic [2:0] len);
        logic [31:0] r;
        case (len)
            3'd1:    r = 32'h0000_3080;
            3'd2:    r = 32'h000E_2080;
            3'd3:    r = 32'h03C8_2080;
            3'd4:    r = 32'hFA08_2080;
            3'd5:    r = 32'h8208_2080;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/utf8t_decode.sv =====
// Sequence decoder: accumulator state plus the single-pass decode of one registered byte.
// Depends on utf8t_pkg for the result types and lookup functions.
module utf8t_decode
    import utf8t_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    input  logic       output_mode,
    output dec_out_t   dec
);

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  len_reg, len_next;

    logic [2:0]  lead_t;
    logic [31:0] acc_step;
    logic [2:0]  rem_step;
    logic [31:0] cp;
    logic [31:0] cp_sub;
    logic        do_emit;
    logic        cut_short;

    always_comb begin
        lead_t   = trail_count(in_byte);
        acc_step = (rem_reg == 3'd0) ? {24'd0, in_byte}
                                     : {acc_reg[25:0], 6'd0} + {24'd0, in_byte};
        rem_step = (rem_reg == 3'd0) ? lead_t : rem_reg - 3'd1;
        len_next = (rem_reg == 3'd0) ? lead_t : len_reg;
        acc_next = acc_step;
        rem_next = rem_step;
        do_emit  = 1'b0;
        cut_short = 1'b0;
        cp       = acc_step - residue(len_next);

        if (rem_reg == 3'd0 && lead_t == 3'd0) begin
            // plain byte or lone continuation byte: pass through
            do_emit  = 1'b1;
            cp       = {24'd0, in_byte};
            acc_next = 32'd0;
            len_next = 3'd0;
        end else if (rem_step != 3'd0) begin
            if (string_end) begin
                // sequence cut short by the end of the string: replace it with a tilde that closes the string
                cut_short = 1'b1;
                acc_next  = 32'd0;
                rem_next  = 3'd0;
                len_next  = 3'd0;
            end
        end else begin
            do_emit  = 1'b1;
            acc_next = 32'd0;
            len_next = 3'd0;
        end
    end

    always_comb begin
        cp_sub    = cp - SUPP_BASE;
        dec.count = 2'd0;
        dec.r0    = '{unit: TILDE_UNIT, last: 1'b1, done: 1'b1};
        dec.r1    = '{unit: {22'd0, cp_sub[9:0]} + SURR_LOW, last: 1'b1, done: string_end};
        if (cut_short) begin
            dec.count = 2'd1;
        end else if (do_emit) begin
            dec.count = 2'd1;
            if (output_mode != MODE_UTF16 || cp <= BMP_MAX) begin
                dec.r0 = '{unit: cp, last: 1'b1, done: string_end};
            end else if (cp > UNI_MAX) begin
                dec.r0 = '{unit: TILDE_UNIT, last: 1'b1, done: string_end};
            end else begin
                dec.count = 2'd2;
                dec.r0    = '{unit: {22'd0, cp_sub[19:10]} + SURR_HIGH, last: 1'b0,
                              done: 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 32'd0;
            rem_reg <= 3'd0;
            len_reg <= 3'd0;
        end else if (fire) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
            len_reg <= len_next;
        end
    end

endmodule

// ===== hw/rtl/utf8t_out_fifo.sv =====
// Result queue: takes up to two results per cycle, presents one per cycle to the master side.
// Depends on utf8t_pkg for result_t.
module utf8t_out_fifo
    import utf8t_pkg::*;
#(
    parameter int unsigned DEPTH = OUT_DEPTH  // power of two, 2 or more
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  logic [1:0] wr_count,
    input  result_t wr_r0,
    input  result_t wr_r1,
    output logic    room_for_two,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_wr;
    logic            pop;

    assign rd_valid     = (cnt_reg != '0);
    assign rd_data      = mem[rptr_reg];
    assign room_for_two = (cnt_reg <= CW'(DEPTH - 2));
    assign pop          = rd_valid && rd_ready;

    always_comb begin
        n_wr      = wr_en ? CW'(wr_count) : '0;
        wptr_next = wptr_reg + PW'(n_wr);
        rptr_next = rptr_reg + PW'(pop);
        cnt_next  = cnt_reg + n_wr - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_count != 2'd0) begin
            mem[wptr_reg] <= wr_r0;
        end
        if (wr_en && wr_count == 2'd2) begin
            mem[wptr_reg + PW'(1)] <= wr_r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/utf8_to_utf16_transcoder.sv =====
// UTF-8 to UTF-16 / UTF-32 transcoder, top level.
// Instantiates utf8t_decode and utf8t_out_fifo; uses utf8t_pkg.
//
// Usage:
//   The slave channel carries one UTF-8 byte per transfer in s_tdata, with s_tlast on
//   the last byte of a string. The master channel gives one result per transfer: a
//   UTF-16 unit (upper half zero) or a full 32-bit code point in m_tdata, m_tlast on
//   the last result caused by one input byte, and m_tuser[0] on the result that closes
//   the string. A byte in the middle of a sequence gives no result; a supplementary
//   code point in UTF-16 mode gives a surrogate pair.
//   The cfg channel writes output_mode (0: UTF-16 units, 1: 32-bit code points); write
//   it only while the block is idle. cfg_ready is always high.
// Timing:
//   A byte in the input register is decoded and its results written to the queue once the
//   queue has room for two results; m_tvalid follows the queue's count register. One byte
//   is taken every cycle while the queue has room for two; the master side drains one
//   result per cycle while m_tready is high, so a surrogate pair takes two transfers and
//   the queue (OUT_FIFO_DEPTH entries) back-pressures s_tready when it lacks that room.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the sequence state, the queue and
//   output_mode. When the receiver stalls, results wait in the queue and the input
//   register holds its byte until the queue has room for two results.
module utf8_to_utf16_transcoder
    import utf8t_pkg::*;
#(
    parameter int unsigned OUT_FIFO_DEPTH = OUT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // string_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] code_unit
    output logic        m_tlast,    // run_last
    output logic [0:0]  m_tuser,    // [0] string_done

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data    // [0] output_mode
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       mode_reg;
    logic       fire;
    logic       room_for_two;
    dec_out_t   dec;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && room_for_two;
    assign s_tready  = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid) begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    // hold the byte until the decoder takes it
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    utf8t_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .in_byte     (in_byte_reg),
        .string_end  (in_last_reg),
        .output_mode (mode_reg),
        .dec         (dec)
    );

    utf8t_out_fifo #(
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (fire),
        .wr_count     (dec.count),
        .wr_r0        (dec.r0),
        .wr_r1        (dec.r1),
        .room_for_two (room_for_two),
        .rd_valid     (m_tvalid),
        .rd_ready     (m_tready),
        .rd_data      (head)
    );

    assign m_tdata    = head.unit;
    assign m_tlast    = head.last;
    assign m_tuser[0] = head.done;

endmodule
